>>> rtl/lac_pkg.sv
`timescale 1ns / 1ps

package lac_pkg;

  localparam int unsigned MAX_LAYERS   = 8;
  localparam int unsigned NUM_LAYERS_DEF = 8;
  localparam int unsigned CHANNELS     = 4;
  localparam int unsigned CH_W         = 8;
  localparam int unsigned PIX_W        = CHANNELS * CH_W;
  localparam int unsigned MASK_W       = MAX_LAYERS;
  localparam int unsigned LAYER_IDX_W  = $clog2(MAX_LAYERS);
  localparam logic [CH_W:0] BLEND_SCALE = 9'd256;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [MASK_W-1:0] mask_t;

  // one pipeline beat: valid bit, running accumulator and the layer pixels
  typedef struct packed {
    logic                        valid;
    pix_t                        acc;
    logic [MAX_LAYERS-1:0][PIX_W-1:0] layers;
  } lac_beat_t;

  // premultiplied over: src + acc * (256 - src_alpha) / 256, per channel, wrapping
  function automatic pix_t blend_layer(pix_t acc, pix_t src);
    logic [CH_W:0]     factor;
    logic [2*CH_W:0]   prod;
    logic [CH_W-1:0]   s;
    logic [CH_W-1:0]   d;
    pix_t              res;
    factor = BLEND_SCALE - {1'b0, src[PIX_W-1 -: CH_W]};
    res    = '0;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      s    = src[ch*CH_W +: CH_W];
      d    = acc[ch*CH_W +: CH_W];
      prod = {{(CH_W+1){1'b0}}, d} * {{CH_W{1'b0}}, factor};
      res[ch*CH_W +: CH_W] = s + prod[2*CH_W-1:CH_W];
    end
    return res;
  endfunction

endpackage

>>> rtl/lac_ifs.sv
`timescale 1ns / 1ps

interface lac_layers_if;
  logic        valid;
  logic        ready;
  logic [31:0] layer0_pixel;
  logic [31:0] layer1_pixel;
  logic [31:0] layer2_pixel;
  logic [31:0] layer3_pixel;
  logic [31:0] layer4_pixel;
  logic [31:0] layer5_pixel;
  logic [31:0] layer6_pixel;
  logic [31:0] layer7_pixel;

  modport source (
    output valid, layer0_pixel, layer1_pixel, layer2_pixel, layer3_pixel,
           layer4_pixel, layer5_pixel, layer6_pixel, layer7_pixel,
    input  ready
  );
  modport sink (
    input  valid, layer0_pixel, layer1_pixel, layer2_pixel, layer3_pixel,
           layer4_pixel, layer5_pixel, layer6_pixel, layer7_pixel,
    output ready
  );
endinterface

interface lac_pixel_if;
  logic        valid;
  logic        ready;
  logic [31:0] composited_pixel;

  modport source (output valid, composited_pixel, input ready);
  modport sink (input valid, composited_pixel, output ready);
endinterface

interface lac_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] connect_mask;

  modport source (output valid, connect_mask, input ready);
  modport sink (input valid, connect_mask, output ready);
endinterface

>>> rtl/layered_alpha_compositor.sv
`timescale 1ns / 1ps
// one registered blend stage per layer, in layer order; out_ch is driven from the last
//   stage's registers
// throughput: one item per cycle while out_ch.ready is high; ready runs combinationally
//   through the stages, so an empty stage always takes an item and a stall loses or repeats nothing
// reset (rst_n low, synchronous): all stage valid bits and connect_mask clear to 0
// config writes are always ready; each stage reads the live mask as an item passes
module layered_alpha_compositor import lac_pkg::*; #(
  parameter int unsigned NUM_LAYERS = NUM_LAYERS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  lac_cfg_if.sink       cfg_ch,
  lac_layers_if.sink    in_ch,
  lac_pixel_if.source   out_ch
);

  mask_t     connect_mask_r;
  mask_t     connect_mask_nxt;
  lac_beat_t beat [NUM_LAYERS+1];
  logic      rdy  [NUM_LAYERS+1];

  assign cfg_ch.ready     = 1'b1;
  assign connect_mask_nxt = (cfg_ch.valid && cfg_ch.ready) ? cfg_ch.connect_mask
                                                           : connect_mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      connect_mask_r <= '0;
    end else begin
      connect_mask_r <= connect_mask_nxt;
    end
  end

  // accumulator starts at zero for every item
  assign beat[0].valid     = in_ch.valid;
  assign beat[0].acc       = '0;
  assign beat[0].layers[0] = in_ch.layer0_pixel;
  assign beat[0].layers[1] = in_ch.layer1_pixel;
  assign beat[0].layers[2] = in_ch.layer2_pixel;
  assign beat[0].layers[3] = in_ch.layer3_pixel;
  assign beat[0].layers[4] = in_ch.layer4_pixel;
  assign beat[0].layers[5] = in_ch.layer5_pixel;
  assign beat[0].layers[6] = in_ch.layer6_pixel;
  assign beat[0].layers[7] = in_ch.layer7_pixel;
  assign in_ch.ready       = rdy[0];

  for (genvar k = 0; k < NUM_LAYERS; k++) begin : g_stage
    lac_stage #(
      .LAYER(k)
    ) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .layer_en  (connect_mask_r[k]),
      .up        (beat[k]),
      .up_ready  (rdy[k]),
      .down      (beat[k+1]),
      .down_ready(rdy[k+1])
    );
  end

  assign rdy[NUM_LAYERS]         = out_ch.ready;
  assign out_ch.valid            = beat[NUM_LAYERS].valid;
  assign out_ch.composited_pixel = beat[NUM_LAYERS].acc;

endmodule

>>> rtl/lac_stage.sv
`timescale 1ns / 1ps

module lac_stage import lac_pkg::*; #(
  parameter int unsigned LAYER = 0
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      layer_en,
  input  lac_beat_t up,
  output logic      up_ready,
  output lac_beat_t down,
  input  logic      down_ready
);

  localparam logic [LAYER_IDX_W-1:0] IDX = LAYER_IDX_W'(LAYER);

  logic      valid_r;
  logic      valid_nxt;
  pix_t      acc_r;
  pix_t      acc_nxt;
  logic [MAX_LAYERS-1:0][PIX_W-1:0] layers_r;

  // stage takes a new item when empty or when its item moves on
  assign up_ready  = !valid_r || down_ready;
  assign valid_nxt = up_ready ? up.valid : valid_r;
  assign acc_nxt   = layer_en ? blend_layer(up.acc, up.layers[IDX]) : up.acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up.valid) begin
      acc_r    <= acc_nxt;
      layers_r <= up.layers;
    end
  end

  assign down.valid  = valid_r;
  assign down.acc    = acc_r;
  assign down.layers = layers_r;

endmodule

>>> rtl/lac_checker.sv
`timescale 1ns / 1ps

module lac_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_pixel
);

  // a result waiting for the sink stays put
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_pixel))
    else $error("result changed while stalled");

  // pipeline comes out of reset empty
  assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a free output end frees the whole chain
  assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while sink is ready");

  assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled while pipeline output is empty");

endmodule

bind layered_alpha_compositor lac_checker u_lac_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_ready (in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_pixel(out_ch.composited_pixel)
);

>>> bench/layered_alpha_compositor_tb.sv
`timescale 1ns / 1ps

module layered_alpha_compositor_tb;
  import lac_pkg::*;

  localparam int unsigned LAYERS       = NUM_LAYERS_DEF;
  localparam int unsigned PHASES       = 9;
  localparam int unsigned PHASE_ITEMS  = 180;
  localparam int unsigned HOLD_CYCLES  = 150;
  localparam int unsigned STALL_LIMIT  = 1000;
  localparam int unsigned DIRECTED_N   = 18;

  typedef logic [MAX_LAYERS-1:0][PIX_W-1:0] layer_set_t;

  typedef struct packed {
    mask_t      mask;
    layer_set_t layers;
    logic       known;
    pix_t       want;
  } directed_row_t;

  localparam layer_set_t MIXED_LAYERS = {
    32'h9911_2233, 32'h00FE_DCBA, 32'hFF01_0101, 32'h7F7F_7F7F,
    32'h0180_C0E0, 32'h6ACE_B00F, 32'h3C3C_3C3C, 32'hC5A5_5A5A
  };

  localparam directed_row_t DIRECTED_ROWS [DIRECTED_N] = '{
    // mask still at its reset value
    '{8'h00, {8{32'h0000_0000}}, 1'b1, 32'h0000_0000},
    '{8'h00, {8{32'hFFFF_FFFF}}, 1'b1, 32'h0000_0000},
    // single layer over an empty accumulator, disabled layers full of ones
    '{8'h01, {{7{32'hFFFF_FFFF}}, 32'h1234_5678}, 1'b1, 32'h1234_5678},
    '{8'h01, {8{32'hFFFF_FFFF}}, 1'b1, 32'hFFFF_FFFF},
    // opaque layer wipes what is below
    '{8'h03, {{6{32'h5555_5555}}, 32'hFF00_0000, 32'h8040_2010}, 1'b1, 32'hFF00_0000},
    // transparent layer adds to what is below
    '{8'h03, {{6{32'hAAAA_AAAA}}, 32'h0001_0203, 32'h8040_2010}, 1'b1, 32'h8041_2213},
    // channel sum wraps
    '{8'h03, {{6{32'h0000_0000}}, 32'h00FF_FFFF, 32'h00FF_FFFF}, 1'b1, 32'h00FE_FEFE},
    // half alpha halves the layer below, truncated
    '{8'h03, {{6{32'h0000_0000}}, 32'h8000_0000, 32'hFFFF_FFFF}, 1'b1, 32'hFF7F_7F7F},
    '{8'h03, {32'h0102_0304, 32'h1122_3344, 32'h2233_4455, 32'h3344_5566,
              32'h4455_6677, 32'h5566_7788, 32'h7F10_2030, 32'hC0A0_B0E0}, 1'b0, '0},
    '{8'h80, {32'hA5A5_A5A5, {7{32'hFFFF_FFFF}}}, 1'b1, 32'hA5A5_A5A5},
    '{8'h81, {32'h40C0_8020, {6{32'h1234_5678}}, 32'hFF80_4020}, 1'b0, '0},
    '{8'hAA, MIXED_LAYERS, 1'b0, '0},
    '{8'h55, MIXED_LAYERS, 1'b0, '0},
    '{8'hFF, {8{32'h0000_0000}}, 1'b1, 32'h0000_0000},
    '{8'hFF, {8{32'hFFFF_FFFF}}, 1'b1, 32'hFFFF_FFFF},
    // eight transparent layers of 0xff wrap to 0xf8
    '{8'hFF, {8{32'h00FF_FFFF}}, 1'b1, 32'h00F8_F8F8},
    '{8'hFF, MIXED_LAYERS, 1'b0, '0},
    '{8'hFF, {8{32'h8080_8080}}, 1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst_n;

  lac_cfg_if    cfg_if ();
  lac_layers_if in_if ();
  lac_pixel_if  out_if ();

  layered_alpha_compositor dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_if),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  always #4 clk = ~clk;

  pix_t        expected_pixels[$];
  pix_t        oldest_pixel;
  mask_t       active_mask;
  int unsigned errors;
  int unsigned items_sent;
  int unsigned pixels_checked;
  int unsigned mask_writes;
  int unsigned holds_done;
  int unsigned burst_left;
  bit          sender_steady;
  int unsigned sink_mode;
  int unsigned hold_cycles;

  // over compositing, bottom layer first, each channel wraps at 8 bits
  function automatic pix_t composite_pixel(input mask_t mask, input layer_set_t layers);
    pix_t        acc;
    pix_t        src;
    int unsigned weight;
    int unsigned s;
    int unsigned d;
    acc = '0;
    for (int k = 0; k < LAYERS; k++) begin
      if (mask[k]) begin
        src    = layers[k];
        weight = 256 - src[31:24];
        for (int ch = 0; ch < CHANNELS; ch++) begin
          s = src[ch*CH_W +: CH_W];
          d = acc[ch*CH_W +: CH_W];
          acc[ch*CH_W +: CH_W] = 8'(s + ((d * weight) >> 8));
        end
      end
    end
    return acc;
  endfunction

  // bias alpha toward the opaque, transparent and half cases
  function automatic pix_t random_pixel();
    pix_t px;
    px = $urandom;
    case ($urandom_range(0, 7))
      0: px = '0;
      1: px = '1;
      2: px[31:24] = 8'h00;
      3: px[31:24] = 8'hFF;
      4: px[31:24] = 8'h80;
      default: ;
    endcase
    return px;
  endfunction

  // called at a falling edge, returns at the falling edge after the item is taken
  task automatic offer_layers(input layer_set_t layers, input logic known, input pix_t want);
    if (!sender_steady && burst_left == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    in_if.valid        <= 1'b1;
    in_if.layer0_pixel <= layers[0];
    in_if.layer1_pixel <= layers[1];
    in_if.layer2_pixel <= layers[2];
    in_if.layer3_pixel <= layers[3];
    in_if.layer4_pixel <= layers[4];
    in_if.layer5_pixel <= layers[5];
    in_if.layer6_pixel <= layers[6];
    in_if.layer7_pixel <= layers[7];
    do @(posedge clk); while (!in_if.ready);
    expected_pixels.insert(expected_pixels.size(),
                           known ? want : composite_pixel(active_mask, layers));
    items_sent++;
    if (burst_left > 0) burst_left--;
    @(negedge clk);
  endtask

  task automatic drain_pixels();
    in_if.valid <= 1'b0;
    burst_left = 0;
    while (expected_pixels.size() != 0) @(negedge clk);
    repeat (LAYERS + 4) @(negedge clk);
  endtask

  task automatic write_mask(input mask_t mask);
    cfg_if.valid        <= 1'b1;
    cfg_if.connect_mask <= mask;
    do @(posedge clk); while (!cfg_if.ready);
    active_mask = mask;
    mask_writes++;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin : stimulus
    mask_t      phase_mask;
    layer_set_t layers;
    rst_n               = 1'b0;
    in_if.valid         = 1'b0;
    in_if.layer0_pixel  = '0;
    in_if.layer1_pixel  = '0;
    in_if.layer2_pixel  = '0;
    in_if.layer3_pixel  = '0;
    in_if.layer4_pixel  = '0;
    in_if.layer5_pixel  = '0;
    in_if.layer6_pixel  = '0;
    in_if.layer7_pixel  = '0;
    cfg_if.valid        = 1'b0;
    cfg_if.connect_mask = '0;
    active_mask         = '0;
    errors              = 0;
    items_sent          = 0;
    pixels_checked      = 0;
    mask_writes         = 0;
    holds_done          = 0;
    burst_left          = 0;
    sender_steady       = 1'b0;
    sink_mode           = 1;
    hold_cycles         = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < DIRECTED_N; i++) begin
      if (DIRECTED_ROWS[i].mask != active_mask) begin
        drain_pixels();
        write_mask(DIRECTED_ROWS[i].mask);
      end
      offer_layers(DIRECTED_ROWS[i].layers, DIRECTED_ROWS[i].known, DIRECTED_ROWS[i].want);
    end

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0, 5:    phase_mask = 8'hFF;
        1:       phase_mask = 8'h00;
        2:       phase_mask = 8'h01;
        3:       phase_mask = 8'h80;
        default: phase_mask = mask_t'($urandom_range(0, 255));
      endcase
      drain_pixels();
      write_mask(phase_mask);
      sink_mode     = p % 3;
      sender_steady = (p == 0) || (p == 5);
      // long receiver hold-off so the pipeline backs up into the input
      if (p == 5) hold_cycles = HOLD_CYCLES;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        for (int k = 0; k < MAX_LAYERS; k++) layers[k] = random_pixel();
        offer_layers(layers, 1'b0, '0);
      end
    end

    drain_pixels();
    $display("%0d items over %0d mask writes, %0d composited pixels checked",
             items_sent, mask_writes, pixels_checked);
    $display("bursty and steady input, three receiver stall patterns, %0d long hold-off(s)",
             holds_done);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : receiver
    int unsigned tick;
    tick         = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      tick++;
      if (hold_cycles != 0) begin
        out_if.ready <= 1'b0;
        repeat (hold_cycles) @(negedge clk);
        hold_cycles = 0;
        holds_done++;
      end
      case (sink_mode)
        0:       out_if.ready <= 1'b1;
        1:       out_if.ready <= ($urandom_range(0, 99) >= 35);
        default: out_if.ready <= (tick % 7 != 2) && (tick % 7 != 3);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: composited_pixel %h arrived with nothing pending", $time,
                 out_if.composited_pixel);
        errors++;
      end else begin
        oldest_pixel = expected_pixels.pop_front();
        pixels_checked++;
        if (out_if.composited_pixel !== oldest_pixel) begin
          $display("%0t: composited_pixel expected %h got %h", $time, oldest_pixel,
                   out_if.composited_pixel);
          errors++;
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("%0t: no item moved for %0d cycles, %0d pixels still pending", $time,
             STALL_LIMIT, expected_pixels.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
